// ----- rtl/dxt1tbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dxt1tbd_pkg;

  localparam int MAX_DIMENSION_DEFAULT = 1024;

  // Position arithmetic: a 10-bit tile index times 8, plus the end check at tile + 1.
  localparam int POS_W   = 14;
  localparam int TILE_W  = 10;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Division by three of a value below 256: (x * 171) >> 9 is exact in that range.
  localparam logic [16:0] RECIP_THIRD = 17'd171;
  localparam int          RECIP_SHIFT = 9;

  localparam int LANES = 4;

  typedef logic [15:0] rgb565_t;
  typedef rgb565_t [3:0] palette_t;

  typedef struct packed {
    logic [1:0]       index;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] width;
    logic [POS_W-1:0] height;
  } lane_in_t;

  typedef struct packed {
    rgb565_t pixel;
    logic    in_image;
  } lane_out_t;

endpackage

`default_nettype wire

// ----- rtl/dxt1tbd_palette.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dxt1tbd_palette (
  input  dxt1tbd_pkg::rgb565_t  color_zero,
  input  dxt1tbd_pkg::rgb565_t  color_one,
  output dxt1tbd_pkg::palette_t palette
);
  import dxt1tbd_pkg::*;

  function automatic logic [7:0] third(input logic [7:0] sum);
    logic [16:0] prod;
    prod = {9'd0, sum} * RECIP_THIRD;
    return prod[RECIP_SHIFT +: 8];
  endfunction

  logic [4:0] r0, r1, b0, b1;
  logic [5:0] g0, g1;
  logic [7:0] r_two, r_one, g_two, g_one, b_two, b_one;
  logic [5:0] r_half, b_half;
  logic [6:0] g_half;

  assign r0 = color_zero[15:11];
  assign g0 = color_zero[10:5];
  assign b0 = color_zero[4:0];
  assign r1 = color_one[15:11];
  assign g1 = color_one[10:5];
  assign b1 = color_one[4:0];

  // Weighted sums: "two" favors color zero, "one" favors color one.
  assign r_two = third({2'd0, r0, 1'b0} + {3'd0, r1});
  assign r_one = third({3'd0, r0} + {2'd0, r1, 1'b0});
  assign g_two = third({1'b0, g0, 1'b0} + {2'd0, g1});
  assign g_one = third({2'd0, g0} + {1'b0, g1, 1'b0});
  assign b_two = third({2'd0, b0, 1'b0} + {3'd0, b1});
  assign b_one = third({3'd0, b0} + {2'd0, b1, 1'b0});

  assign r_half = {1'b0, r0} + {1'b0, r1};
  assign g_half = {1'b0, g0} + {1'b0, g1};
  assign b_half = {1'b0, b0} + {1'b0, b1};

  always_comb begin
    palette[0] = color_zero;
    palette[1] = color_one;
    if (color_zero > color_one) begin
      palette[2] = {r_two[4:0], g_two[5:0], b_two[4:0]};
      palette[3] = {r_one[4:0], g_one[5:0], b_one[4:0]};
    end else begin
      palette[2] = {r_half[5:1], g_half[6:1], b_half[5:1]};
      palette[3] = '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dxt1tbd_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dxt1tbd_lane #(
  parameter int LANE = 0
) (
  input  dxt1tbd_pkg::palette_t  palette,
  input  dxt1tbd_pkg::lane_in_t  lane_in,
  output dxt1tbd_pkg::lane_out_t lane_out
);
  import dxt1tbd_pkg::*;

  logic [POS_W-1:0] column;

  assign column = lane_in.x + POS_W'(LANE);

  assign lane_out.pixel    = palette[lane_in.index];
  assign lane_out.in_image = (column < lane_in.width) && (lane_in.y < lane_in.height);

endmodule

`default_nettype wire

// ----- rtl/dxt1_tiled_block_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: one 4x4 sub-block
// m_axis    out        m_axis_tvalid/tready       tdata/tlast/tuser: one pixel row
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// The row register in front of the output emits one pixel row per cycle while m_axis is
// not stalled, and the next sub-block is accepted in the cycle its last row moves.
// A transfer loads the hold registers; the first row then moves on to the output register.
// Reset clears the tile position, the valid flags and the size registers (1024 x 1024).
// A stall on m_axis holds the output register and the row counter; cfg is always ready.

module dxt1_tiled_block_decoder #(
  parameter int MAX_DIMENSION = dxt1tbd_pkg::MAX_DIMENSION_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // color_zero[15:0], color_one[31:16], row_zero_indices[39:32],
  // row_one_indices[47:40], row_two_indices[55:48], row_three_indices[63:56]
  input  wire  [63:0]                           s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // pixel_x[9:0], pixel_y[19:10], pixel_a[35:20], pixel_b[51:36],
  // pixel_c[67:52], pixel_d[83:68], write_mask[87:84]
  output logic [87:0]                           m_axis_tdata,
  output logic                                  m_axis_tlast,  // last_of_block
  output logic                                  m_axis_tuser,  // image_done
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [dxt1tbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [dxt1tbd_pkg::CFG_W-1:0]         cfg_data
);
  import dxt1tbd_pkg::*;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_DIMENSION);

  function automatic logic [POS_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [POS_W-1:0] ext;
    ext = {{(POS_W-CFG_W){1'b0}}, v};
    if (ext == '0) return POS_W'(1);
    if (ext > MAX_POS) return MAX_POS;
    return ext;
  endfunction

  logic [CFG_W-1:0]  image_width, image_height;
  logic [TILE_W-1:0] tile_column, tile_row;
  logic [1:0]        sub_block_number;

  logic              hold_valid;
  logic [1:0]        hold_row;
  palette_t          hold_palette;
  logic [3:0][7:0]   hold_indices;
  logic [POS_W-1:0]  hold_bx, hold_by;
  logic              hold_final;

  logic              out_valid;
  logic [COORD_W-1:0] out_x, out_y;
  rgb565_t [3:0]     out_pixel;
  logic [3:0]        out_mask;
  logic              out_last, out_done;

  logic [POS_W-1:0]  width_eff, height_eff;
  logic              last_col, last_row;
  logic              in_fire, out_free, emit, hold_done;
  palette_t          new_palette;
  logic [POS_W-1:0]  new_bx, new_by, row_y;
  logic [7:0]        row_byte;
  lane_in_t          lane_in  [LANES];
  lane_out_t         lane_out [LANES];

  assign width_eff  = clamp_dim(image_width);
  assign height_eff = clamp_dim(image_height);

  assign last_col = {({1'b0, tile_column} + (TILE_W+1)'(1)), 3'b000} >= width_eff;
  assign last_row = {({1'b0, tile_row} + (TILE_W+1)'(1)), 3'b000} >= height_eff;

  assign new_bx = {1'b0, tile_column, 3'b000} + {{(POS_W-3){1'b0}}, sub_block_number[0], 2'b00};
  assign new_by = {1'b0, tile_row, 3'b000} + {{(POS_W-3){1'b0}}, sub_block_number[1], 2'b00};

  assign out_free      = !out_valid || m_axis_tready;
  assign emit          = hold_valid && out_free;
  assign hold_done     = emit && (hold_row == 2'd3);
  assign s_axis_tready = !hold_valid || hold_done;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  dxt1tbd_palette u_palette (
    .color_zero (s_axis_tdata[15:0]),
    .color_one  (s_axis_tdata[31:16]),
    .palette    (new_palette)
  );

  assign row_byte = hold_indices[hold_row];
  assign row_y    = hold_by + POS_W'(hold_row);

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign lane_in[l].index  = row_byte[2*l +: 2];
    assign lane_in[l].x      = hold_bx;
    assign lane_in[l].y      = row_y;
    assign lane_in[l].width  = width_eff;
    assign lane_in[l].height = height_eff;

    dxt1tbd_lane #(.LANE(l)) u_lane (
      .palette  (hold_palette),
      .lane_in  (lane_in[l]),
      .lane_out (lane_out[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tile walk: four sub-blocks per tile, tiles row-major, wrap after the last tile.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_column      <= '0;
      tile_row         <= '0;
      sub_block_number <= '0;
    end else if (in_fire) begin
      sub_block_number <= sub_block_number + 2'd1;
      if (sub_block_number == 2'd3) begin
        if (last_col) begin
          tile_column <= '0;
          tile_row    <= last_row ? '0 : tile_row + TILE_W'(1);
        end else begin
          tile_column <= tile_column + TILE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_row   <= '0;
    end else if (in_fire) begin
      hold_valid <= 1'b1;
      hold_row   <= '0;
    end else if (emit) begin
      hold_valid <= (hold_row != 2'd3);
      hold_row   <= hold_row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_palette <= new_palette;
      hold_indices <= s_axis_tdata[63:32];
      hold_bx      <= new_bx;
      hold_by      <= new_by;
      hold_final   <= (sub_block_number == 2'd3) && last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x    <= hold_bx[COORD_W-1:0];
      out_y    <= row_y[COORD_W-1:0];
      for (int l = 0; l < LANES; l++) begin
        out_pixel[l] <= lane_out[l].pixel;
        out_mask[l]  <= lane_out[l].in_image;
      end
      out_last <= (hold_row == 2'd3);
      out_done <= (hold_row == 2'd3) && hold_final;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_mask, out_pixel[3], out_pixel[2], out_pixel[1], out_pixel[0],
                          out_y, out_x};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_done;

`ifndef ASSERT_OFF
  a_no_accept_mid_block: assert property (@(posedge clk) disable iff (rst)
    hold_valid && (hold_row != 2'd3) |-> !s_axis_tready)
    else $error("input taken while a sub-block still has rows to emit");

  a_start_at_row_zero: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> hold_valid && (hold_row == 2'd0))
    else $error("accepted sub-block does not start at row zero");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    emit && (hold_row != 2'd3) |=> hold_valid && (hold_row == $past(hold_row) + 2'd1))
    else $error("row counter skipped or lost a row");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_last)
    else $error("image end flagged on a row that is not the last of its block");
`endif

endmodule

`default_nettype wire

// ----- test/dxt1_tiled_block_decoder_tb.sv -----
`timescale 1ns / 1ps

module dxt1_tiled_block_decoder_tb;
  import dxt1tbd_pkg::*;

  localparam int MAX_DIM = 1024;

  typedef struct packed {
    logic [3:0][7:0] idx;  // index byte per block row, row 0 lowest
    logic [15:0]     c1;
    logic [15:0]     c0;
  } subblock_t;

  typedef struct packed {
    logic            done;
    logic            last;
    logic [3:0]      mask;
    logic [3:0][15:0] pix;
    logic [9:0]      y;
    logic [9:0]      x;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Decoder state as the testbench expects it.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned tile_col;
  int unsigned tile_row;
  int unsigned quadrant;

  pixel_row_t expected_rows[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  dxt1_tiled_block_decoder dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Weighted per-channel mix of two RGB565 colors, truncated.
  function automatic logic [15:0] blend565(logic [15:0] a, logic [15:0] b,
                                           int wa, int wb, int dv);
    int r;
    int g;
    int bl;
    r = (int'(a[15:11]) * wa + int'(b[15:11]) * wb) / dv;
    g = (int'(a[10:5]) * wa + int'(b[10:5]) * wb) / dv;
    bl = (int'(a[4:0]) * wa + int'(b[4:0]) * wb) / dv;
    return {r[4:0], g[5:0], bl[4:0]};
  endfunction

  task automatic reset_decoder_state();
    width_reg = DIM_RESET;
    height_reg = DIM_RESET;
    tile_col = 0;
    tile_row = 0;
    quadrant = 0;
  endtask

  task automatic predict_rows(subblock_t blk);
    int unsigned w;
    int unsigned h;
    int unsigned bx;
    int unsigned by;
    int unsigned y;
    bit last_col;
    bit last_row;
    logic [15:0] pal [4];
    pixel_row_t r;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    bx = tile_col * 8 + (quadrant & 1) * 4;
    by = tile_row * 8 + ((quadrant >> 1) & 1) * 4;
    last_col = (tile_col + 1) * 8 >= w;
    last_row = (tile_row + 1) * 8 >= h;
    pal[0] = blk.c0;
    pal[1] = blk.c1;
    if (blk.c0 > blk.c1) begin
      pal[2] = blend565(blk.c0, blk.c1, 2, 1, 3);
      pal[3] = blend565(blk.c0, blk.c1, 1, 2, 3);
    end else begin
      pal[2] = blend565(blk.c0, blk.c1, 1, 1, 2);
      pal[3] = 16'h0000;
    end
    for (int py = 0; py < 4; py++) begin
      y = by + py;
      r = '0;
      r.x = bx[9:0];
      r.y = y[9:0];
      for (int px = 0; px < 4; px++) begin
        r.pix[px] = pal[blk.idx[py][2*px +: 2]];
        r.mask[px] = (bx + px < w) && (y < h);
      end
      r.last = (py == 3);
      r.done = (py == 3) && (quadrant == 3) && last_col && last_row;
      expected_rows.push_back(r);
    end
    // Step to the next sub-block; a finished tile moves right or wraps.
    if (quadrant < 3) begin
      quadrant++;
    end else begin
      quadrant = 0;
      if (last_col) begin
        tile_col = 0;
        tile_row = last_row ? 0 : ((tile_row + 1) & 10'h3FF);
      end else begin
        tile_col = (tile_col + 1) & 10'h3FF;
      end
    end
  endtask

  // Drives one sub-block and returns at the edge where the transfer happens.
  task automatic send_block(subblock_t blk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= blk;
    // The results cannot appear before the transfer, so predicting now is safe.
    predict_rows(blk);
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic wait_all_rows();
    s_axis_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic set_image_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_all_rows();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic subblock_t make_block(logic [15:0] c0, logic [15:0] c1,
                                           logic [31:0] rows);
    subblock_t b;
    b.c0 = c0;
    b.c1 = c1;
    b.idx = rows;
    return b;
  endfunction

  function automatic subblock_t random_block();
    subblock_t b;
    b.c0 = 16'($urandom_range(16'hFFFF));
    b.c1 = 16'($urandom_range(16'hFFFF));
    b.idx = $urandom();
    case ($urandom_range(3))
      0: b.c1 = b.c0;  // equal endpoints select the three-color palette
      1: if (b.c0 <= b.c1) {b.c0, b.c1} = {b.c1, b.c0};
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [CFG_W-1:0] random_dim();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 11'd0;
          1: return 11'd1;
          2: return 11'd1024;
          default: return 11'd2047;
        endcase
      end
      1: return CFG_W'($urandom_range(2047));
      default: return CFG_W'($urandom_range(1, 24));
    endcase
  endfunction

  always @(posedge clk) begin
    pixel_row_t got;
    pixel_row_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[9:0];
      got.y = m_axis_tdata[19:10];
      got.pix = m_axis_tdata[83:20];
      got.mask = m_axis_tdata[87:84];
      got.last = m_axis_tlast;
      got.done = m_axis_tuser;
      if (expected_rows.size() == 0) begin
        report_mismatch("row with nothing expected", 64'({got.y, got.x}), '0);
      end else begin
        want = expected_rows.pop_front();
        if (got.x !== want.x) report_mismatch("pixel_x", 64'(got.x), 64'(want.x));
        if (got.y !== want.y) report_mismatch("pixel_y", 64'(got.y), 64'(want.y));
        for (int n = 0; n < 4; n++)
          if (got.pix[n] !== want.pix[n])
            report_mismatch($sformatf("pixel %0d at y %0d", n, want.y),
                            64'(got.pix[n]), 64'(want.pix[n]));
        if (got.mask !== want.mask)
          report_mismatch("write_mask", 64'(got.mask), 64'(want.mask));
        if (got.last !== want.last)
          report_mismatch("last_of_block", 64'(got.last), 64'(want.last));
        if (got.done !== want.done)
          report_mismatch("image_done", 64'(got.done), 64'(want.done));
      end
    end
  end

  // Endpoint extremes, both palette modes and every index value.
  task automatic test_palette_modes();
    send_block(make_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4));
    send_block(make_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4));
    send_block(make_block(16'h8410, 16'h8410, 32'h1B1B_1B1B));
    send_block(make_block(16'hF800, 16'h07E0, 32'hFFAA_5500));
    send_block(make_block(16'h001F, 16'hF81F, 32'h00FF_39C6));
    send_block(make_block(16'hFFFF, 16'hFFFE, 32'hE41B_D872));
    send_block(make_block(16'hFFFE, 16'hFFFF, 32'h72D8_1BE4));
    send_block(make_block(16'h0001, 16'h0000, 32'hFFFF_FFFF));
  endtask

  // Out-of-range sizes clamp, and shrinking mid-image clips and wraps.
  task automatic test_size_extremes();
    set_image_size(11'd0, 11'd2047);
    repeat (6) send_block(random_block());
    set_image_size(11'd1, 11'd1);
    repeat (6) send_block(random_block());
    set_image_size(11'd2047, 11'd0);
    repeat (4) send_block(random_block());
    set_image_size(11'd1024, 11'd1024);
    repeat (4) send_block(random_block());
  endtask

  // Random sizes with runs of random sub-blocks; each size change waits for idle.
  task automatic test_random_traffic(int sender_pct, int receiver_pct, int count);
    int sent;
    int run;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent = 0;
    while (sent < count) begin
      set_image_size(random_dim(), random_dim());
      run = $urandom_range(8, 24);
      for (int i = 0; i < run && sent < count; i++) begin
        send_block(random_block());
        sent++;
      end
    end
  endtask

  initial begin
    reset_decoder_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_palette_modes();
    test_size_extremes();
    test_random_traffic(13, 50, 100);
    test_random_traffic(50, 13, 100);
    test_random_traffic(0, 0, 100);
    wait_all_rows();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("dxt1_tiled_block_decoder_tb: PASS");
    end else begin
      $display("dxt1_tiled_block_decoder_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("dxt1_tiled_block_decoder_tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dxt1tbd_pkg.sv
rtl/dxt1tbd_palette.sv
rtl/dxt1tbd_lane.sv
rtl/dxt1_tiled_block_decoder.sv
test/dxt1_tiled_block_decoder_tb.sv
